FILE: hw/rtl/ksg_pkg.sv
`timescale 1ns / 1ps

package ksg_pkg;

	// field and storage widths
	localparam int DIGIT_W     = 4;
	localparam int LEN_W       = 4;
	localparam int RADIX_W     = 5;
	localparam int INDEX_W     = 33;
	localparam int CHAR_W      = 8;
	localparam int TEXT_W      = 64;
	localparam int CHARS_W     = 128;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	// powers of the radix up to 16^8 and their running sum
	localparam int POW_W   = 33;
	localparam int SUM_W   = 34;
	localparam int TRIAL_W = POW_W + DIGIT_W - 1;

	// register values after reset
	localparam logic [RADIX_W-1:0] RST_ALPHABET_SIZE = 5'd1;
	localparam logic [LEN_W-1:0]   RST_MAX_LENGTH    = 4'd8;

	// defaults of the top level parameters
	localparam int DEF_MAX_ALPHABET = 16;
	localparam int DEF_MAX_WORD     = 8;

	// action codes carried in the input tuser
	localparam logic ACT_SEEK    = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHABET_SIZE = 2'd0,
		CFG_MAX_LENGTH    = 2'd1,
		CFG_CHARS_LOW     = 2'd2,
		CFG_CHARS_HIGH    = 2'd3
	} cfg_reg_t;

	// digit write from the seek unit into one cell
	typedef struct packed {
		logic                 wr_en;
		logic [LEN_W-1:0]     pos;
		logic [DIGIT_W-1:0]   digit;
	} ksg_wr_t;

	// seek completion status
	typedef struct packed {
		logic             fin;
		logic             ok;
		logic [LEN_W-1:0] len;
	} ksg_fin_t;

	// control shared by all digit cells
	typedef struct packed {
		logic             inc;
		logic             clr;
		ksg_wr_t          wr;
		logic [LEN_W-1:0] len;
	} ksg_cell_ctl_t;

endpackage

FILE: hw/rtl/ksg_cell.sv
`timescale 1ns / 1ps

// One digit position of the candidate word. Carry enters from the next
// (less significant) position and leaves toward the previous one.
module ksg_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [ksg_pkg::RADIX_W-1:0]        n,
	input  ksg_pkg::ksg_cell_ctl_t             ctl,
	input  logic [ksg_pkg::CHARS_W-1:0]        chars,
	input  logic                               carry_in,
	output logic                               carry_out,
	output logic [ksg_pkg::CHAR_W-1:0]         ch
);

	logic [ksg_pkg::DIGIT_W-1:0] digit_q;
	logic [ksg_pkg::RADIX_W-1:0] digit_inc;
	logic                        active;
	logic                        wrap;
	logic                        wr_hit;

	// position lies inside the current word
	assign active    = ksg_pkg::LEN_W'(IDX) < ctl.len;
	assign digit_inc = {1'b0, digit_q} + ksg_pkg::RADIX_W'(1);
	assign wrap      = digit_inc >= n;
	assign carry_out = active ? (carry_in & wrap) : carry_in;
	assign wr_hit    = ctl.wr.wr_en && (ctl.wr.pos == ksg_pkg::LEN_W'(IDX));

	// digit update: length rollover clears, seek writes, advance counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clr) begin
			digit_q <= '0;
		end else if (wr_hit) begin
			digit_q <= ctl.wr.digit;
		end else if (ctl.inc && active && carry_in) begin
			digit_q <= wrap ? '0 : digit_inc[ksg_pkg::DIGIT_W-1:0];
		end
	end

	// character lookup, zero beyond the word
	assign ch = active ? chars[{digit_q, 3'b000} +: ksg_pkg::CHAR_W] : '0;

endmodule

FILE: hw/rtl/ksg_seek.sv
`timescale 1ns / 1ps

// Maps a key-space index to a word length and digits. The length search
// tries one length at a time; each digit takes four restoring steps against
// the stored power of the radix for its position.
module ksg_seek #(
	parameter int MAX_WORD = ksg_pkg::DEF_MAX_WORD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ksg_pkg::INDEX_W-1:0]   idx,
	input  logic [ksg_pkg::RADIX_W-1:0]   n,
	input  logic [ksg_pkg::LEN_W-1:0]     lim,
	output logic                          busy,
	output ksg_pkg::ksg_wr_t              wr,
	output ksg_pkg::ksg_fin_t             fin
);

	localparam int POS_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	typedef enum logic [1:0] {
		SK_IDLE,
		SK_LEN,
		SK_DIG
	} seek_state_t;

	seek_state_t state_q;

	logic [ksg_pkg::INDEX_W-1:0] idx_q;
	logic [ksg_pkg::POW_W-1:0]   p_q;
	logic [ksg_pkg::SUM_W-1:0]   sum_q;
	logic [ksg_pkg::LEN_W-1:0]   i_q;
	logic [ksg_pkg::LEN_W-1:0]   len_q;
	logic [ksg_pkg::LEN_W-1:0]   pos_q;
	logic [1:0]                  bit_q;
	logic [ksg_pkg::DIGIT_W-1:0] q_q;
	logic [ksg_pkg::INDEX_W-1:0] r_q;
	logic [ksg_pkg::POW_W-1:0]   pow_q [MAX_WORD];

	logic [ksg_pkg::SUM_W-1:0]               sum_p;
	logic                                    hit;
	logic                                    last_len;
	logic [ksg_pkg::POW_W+ksg_pkg::RADIX_W-1:0] prod;
	logic [ksg_pkg::SUM_W-1:0]               diff;
	logic [ksg_pkg::LEN_W-1:0]               k;
	logic [ksg_pkg::POW_W-1:0]               pow_sel;
	logic [ksg_pkg::TRIAL_W-1:0]             trial;
	logic [ksg_pkg::TRIAL_W-1:0]             r_ext;
	logic [ksg_pkg::TRIAL_W-1:0]             r_sub;
	logic                                    ge;
	logic                                    last_pos;

	// length search: index below sum of powers up to this length
	assign sum_p    = sum_q + {1'b0, p_q};
	assign hit      = {1'b0, idx_q} < sum_p;
	assign last_len = i_q == lim;
	assign prod     = p_q * n;
	assign diff     = {1'b0, idx_q} - sum_q;

	// digit extraction: one quotient bit per cycle, most significant first
	assign k        = len_q - pos_q - ksg_pkg::LEN_W'(1);
	assign pow_sel  = pow_q[k[POS_W-1:0]];
	assign trial    = {{(ksg_pkg::DIGIT_W-1){1'b0}}, pow_sel} << bit_q;
	assign r_ext    = {{(ksg_pkg::DIGIT_W-1){1'b0}}, r_q};
	assign ge       = r_ext >= trial;
	assign r_sub    = r_ext - trial;
	assign last_pos = pos_q == (len_q - ksg_pkg::LEN_W'(1));

	assign busy     = state_q != SK_IDLE;

	assign wr.wr_en = (state_q == SK_DIG) && (bit_q == 2'd0);
	assign wr.pos   = pos_q;
	assign wr.digit = q_q | ksg_pkg::DIGIT_W'(ge);

	assign fin.fin  = ((state_q == SK_LEN) && !hit && last_len) ||
	                  ((state_q == SK_DIG) && (bit_q == 2'd0) && last_pos);
	assign fin.ok   = state_q == SK_DIG;
	assign fin.len  = len_q;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SK_IDLE;
		end else begin
			unique case (state_q)
				SK_IDLE: begin
					if (start) state_q <= SK_LEN;
				end
				SK_LEN: begin
					if (hit) state_q <= SK_DIG;
					else if (last_len) state_q <= SK_IDLE;
				end
				SK_DIG: begin
					if (bit_q == 2'd0 && last_pos) state_q <= SK_IDLE;
				end
				default: state_q <= SK_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			SK_IDLE: begin
				if (start) begin
					idx_q    <= idx;
					p_q      <= ksg_pkg::POW_W'(n);
					sum_q    <= '0;
					i_q      <= ksg_pkg::LEN_W'(1);
					pow_q[0] <= ksg_pkg::POW_W'(1);
				end
			end
			SK_LEN: begin
				if (i_q < ksg_pkg::LEN_W'(MAX_WORD)) pow_q[i_q[POS_W-1:0]] <= p_q;
				if (hit) begin
					len_q <= i_q;
					r_q   <= diff[ksg_pkg::INDEX_W-1:0];
					pos_q <= '0;
					bit_q <= 2'd3;
					q_q   <= '0;
				end else begin
					sum_q <= sum_p;
					p_q   <= prod[ksg_pkg::POW_W-1:0];
					i_q   <= i_q + ksg_pkg::LEN_W'(1);
				end
			end
			SK_DIG: begin
				if (ge) r_q <= r_sub[ksg_pkg::INDEX_W-1:0];
				if (bit_q == 2'd0) begin
					q_q   <= '0;
					bit_q <= 2'd3;
					pos_q <= pos_q + ksg_pkg::LEN_W'(1);
				end else begin
					q_q   <= q_q | (ksg_pkg::DIGIT_W'(ge) << bit_q);
					bit_q <= bit_q - 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/keyspace_candidate_generator.sv
`timescale 1ns / 1ps

// Advance: accepted every cycle while the output is not stalled; the result
//   goes pending, is captured into the output register, then sits there.
// Seek: length search up to max_length (one power per cycle), then one digit
//   at a time in the shared restoring divider; input is held off.
// Reset (arst_n low, asynchronous): digits zero, length one, not exhausted,
//   radix 1, max length 8, alphabet characters zero, output empty.
module keyspace_candidate_generator #(
	parameter int MAX_ALPHABET = ksg_pkg::DEF_MAX_ALPHABET,
	parameter int MAX_WORD     = ksg_pkg::DEF_MAX_WORD
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [32:0] start_index, rest zero
	input  logic [ksg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [0] action
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [63:0] candidate_text, [67:64] candidate_length, rest zero
	output logic [ksg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// [0] exhausted
	output logic                              m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [ksg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksg_pkg::CFG_W-1:0]         cfg_data
);

	logic [ksg_pkg::RADIX_W-1:0] alphabet_size_q;
	logic [ksg_pkg::LEN_W-1:0]   max_length_q;
	logic [ksg_pkg::CHARS_W-1:0] chars_q;

	logic [ksg_pkg::LEN_W-1:0]   wl_q;
	logic                        done_q;
	logic                        res_pend_q;

	logic                        out_valid_q;
	logic [ksg_pkg::TEXT_W-1:0]  out_text_q;
	logic [ksg_pkg::LEN_W-1:0]   out_len_q;
	logic                        out_exh_q;

	logic [ksg_pkg::RADIX_W-1:0] n;
	logic [ksg_pkg::LEN_W-1:0]   lim;
	logic                        in_acc;
	logic                        is_adv;
	logic                        seek_start;
	logic                        adv;
	logic                        out_load;
	logic                        seek_busy;
	logic [MAX_WORD:0]           carry;
	logic [ksg_pkg::LEN_W-1:0]   adv_len;
	logic                        adv_over;
	logic [ksg_pkg::TEXT_W-1:0]  text;
	logic [ksg_pkg::CHAR_W-1:0]  ch [MAX_WORD];

	ksg_pkg::ksg_wr_t            seek_wr;
	ksg_pkg::ksg_fin_t           seek_fin;
	ksg_pkg::ksg_cell_ctl_t      cell_ctl;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_size_q <= ksg_pkg::RST_ALPHABET_SIZE;
			max_length_q    <= ksg_pkg::RST_MAX_LENGTH;
			chars_q         <= '0;
		end else if (cfg_we) begin
			unique case (ksg_pkg::cfg_reg_t'(cfg_index))
				ksg_pkg::CFG_ALPHABET_SIZE:
					alphabet_size_q <= cfg_data[ksg_pkg::RADIX_W-1:0];
				ksg_pkg::CFG_MAX_LENGTH:
					max_length_q <= cfg_data[ksg_pkg::LEN_W-1:0];
				ksg_pkg::CFG_CHARS_LOW:
					chars_q[ksg_pkg::CFG_W-1:0] <= cfg_data;
				ksg_pkg::CFG_CHARS_HIGH:
					chars_q[ksg_pkg::CHARS_W-1:ksg_pkg::CFG_W] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// radix and length bound clamped to the supported range
	always_comb begin
		if (alphabet_size_q == '0) n = ksg_pkg::RADIX_W'(1);
		else if (alphabet_size_q > ksg_pkg::RADIX_W'(MAX_ALPHABET))
			n = ksg_pkg::RADIX_W'(MAX_ALPHABET);
		else n = alphabet_size_q;
		if (max_length_q == '0) lim = ksg_pkg::LEN_W'(1);
		else if (max_length_q > ksg_pkg::LEN_W'(MAX_WORD))
			lim = ksg_pkg::LEN_W'(MAX_WORD);
		else lim = max_length_q;
	end

	// handshake
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_adv        = s_axis_tuser == ksg_pkg::ACT_ADVANCE;
	assign seek_start    = in_acc && !is_adv;
	assign adv           = in_acc && is_adv && !done_q;
	assign out_load      = res_pend_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !seek_busy && (!res_pend_q || out_load);

	ksg_seek #(
		.MAX_WORD (MAX_WORD)
	) u_seek (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seek_start),
		.idx    (s_axis_tdata[ksg_pkg::INDEX_W-1:0]),
		.n      (n),
		.lim    (lim),
		.busy   (seek_busy),
		.wr     (seek_wr),
		.fin    (seek_fin)
	);

	// digit cells, carry ripples from the last position to the first
	assign carry[MAX_WORD] = 1'b1;
	assign cell_ctl.inc    = adv;
	assign cell_ctl.clr    = adv && carry[0];
	assign cell_ctl.wr     = seek_wr;
	assign cell_ctl.len    = wl_q;

	for (genvar gi = 0; gi < MAX_WORD; gi++) begin : g_cell
		ksg_cell #(
			.IDX (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.n         (n),
			.ctl       (cell_ctl),
			.chars     (chars_q),
			.carry_in  (carry[gi+1]),
			.carry_out (carry[gi]),
			.ch        (ch[gi])
		);
	end

	// word length and exhausted flag
	assign adv_len  = carry[0] ? (wl_q + ksg_pkg::LEN_W'(1)) : wl_q;
	assign adv_over = adv_len > lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= ksg_pkg::LEN_W'(1);
			done_q <= 1'b0;
		end else if (seek_fin.fin) begin
			if (seek_fin.ok) begin
				wl_q   <= seek_fin.len;
				done_q <= 1'b0;
			end else begin
				done_q <= 1'b1;
			end
		end else if (adv) begin
			if (adv_over) done_q <= 1'b1;
			else wl_q <= adv_len;
		end
	end

	// result pending until captured into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((in_acc && is_adv) || seek_fin.fin) res_pend_q <= 1'b1;
			else if (out_load) res_pend_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		text = '0;
		for (int i = 0; i < MAX_WORD; i++) text[i*ksg_pkg::CHAR_W +: ksg_pkg::CHAR_W] = ch[i];
	end

	// output word
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_text_q <= done_q ? '0 : text;
			out_len_q  <= done_q ? '0 : wl_q;
			out_exh_q  <= done_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(ksg_pkg::OUT_TDATA_W - ksg_pkg::TEXT_W - ksg_pkg::LEN_W){1'b0}},
	                        out_len_q, out_text_q};
	assign m_axis_tuser  = out_exh_q;

	// no input taken while a seek runs
	a_seek_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		seek_busy |-> !s_axis_tready)
		else $error("input accepted during seek");

	// a running seek never overlaps an uncaptured result
	a_seek_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		seek_busy |-> !res_pend_q)
		else $error("result pending during seek");

	// stored word length stays within the cell row
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wl_q >= ksg_pkg::LEN_W'(1)) && (wl_q <= ksg_pkg::LEN_W'(MAX_WORD)))
		else $error("word length out of range");

	// every seek completion produces one pending result
	a_fin_pends: assert property (@(posedge clk) disable iff (!arst_n)
		seek_fin.fin |=> res_pend_q && !seek_busy)
		else $error("seek completion lost");

endmodule
